// File: rtl/core/htsc_pkg.sv
package htsc_pkg;

    localparam int SAMPLE_W = 15;
    localparam int LEVEL_W  = 23;
    localparam int TIME_W   = 32;
    localparam int SQ_W     = 2 * LEVEL_W;

    localparam logic [LEVEL_W-1:0] RESET_LEVEL = 23'd1638400;
    localparam logic [LEVEL_W-1:0] PEAK_MULT   = 23'd160;
    localparam int MIN_PEAKS  = 4;
    localparam int MIN_GOOD   = 3;
    localparam int DRIFT_DIV  = 20;
    localparam int DRIFT_KEEP = 19;
    localparam int DRIFT_RND  = 10;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_GAP_MIN   = 2'd1;
    localparam logic [1:0] REG_GAP_MAX   = 2'd2;
    localparam logic [1:0] REG_DRIFT     = 2'd3;

    typedef struct packed {
        logic [22:0] sound_threshold;
        logic [15:0] gap_min_ms;
        logic [15:0] gap_max_ms;
        logic [19:0] force_drift_ms;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SQ,
        ST_ACC,
        ST_RH_INIT,
        ST_RH_RD,
        ST_RH_CMP,
        ST_EN_SQ,
        ST_EN_DEC,
        ST_Q_RD,
        ST_LV_UPD,
        ST_DIV,
        ST_NEXT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic eval;
        logic sq_dev;
        logic acc;
        logic rh_init;
        logic rh_cmp;
        logic sq_lvl;
        logic decide;
        logic lv_upd;
        logic lv_write;
        logic out_load;
        logic ch;
    } cmd_t;

    typedef struct packed {
        logic win_end;
        logic rh_short;
        logic rh_last;
        logic need_div;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

// File: rtl/core/htsc_if.sv
interface htsc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] time_ms;
    logic [14:0] sample_a;
    logic [14:0] sample_b;

    modport source (output valid, time_ms, sample_a, sample_b, input ready);
    modport sink (input valid, time_ms, sample_a, sample_b, output ready);
endinterface

interface htsc_out_if;
    logic        valid;
    logic        ready;
    logic        sound_a;
    logic        heart_a;
    logic        bowel_a;
    logic [22:0] level_a;
    logic [22:0] dev_a;
    logic        sound_b;
    logic        heart_b;
    logic        bowel_b;
    logic [22:0] level_b;
    logic [22:0] dev_b;

    modport source (output valid, sound_a, heart_a, bowel_a, level_a, dev_a,
                    sound_b, heart_b, bowel_b, level_b, dev_b, input ready);
    modport sink (input valid, sound_a, heart_a, bowel_a, level_a, dev_a,
                  sound_b, heart_b, bowel_b, level_b, dev_b, output ready);
endinterface

// File: rtl/core/htsc_div.sv
module htsc_div
    import htsc_pkg::*;
#(
    parameter int DIV_W = 31,
    parameter int DVS_W = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;
    logic             fits;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        fits      = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : DVS_W'(trial);
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/core/htsc_ctrl.sv
module htsc_ctrl
    import htsc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   ch_reg, ch_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ch_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        cmd        = '0;
        cmd.ch     = ch_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    ch_next     = 1'b0;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.sq_dev = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = stat.win_end ? ST_RH_INIT : ST_Q_RD;
            end
            ST_RH_INIT:
            begin
                cmd.rh_init = 1'b1;
                state_next  = stat.rh_short ? ST_EN_SQ : ST_RH_RD;
            end
            ST_RH_RD:
            begin
                state_next = ST_RH_CMP;
            end
            ST_RH_CMP:
            begin
                cmd.rh_cmp = 1'b1;
                state_next = stat.rh_last ? ST_EN_SQ : ST_RH_RD;
            end
            ST_EN_SQ:
            begin
                cmd.sq_lvl = 1'b1;
                state_next = ST_EN_DEC;
            end
            ST_EN_DEC:
            begin
                cmd.decide = 1'b1;
                state_next = ST_Q_RD;
            end
            ST_Q_RD:
            begin
                state_next = ST_LV_UPD;
            end
            ST_LV_UPD:
            begin
                cmd.lv_upd = 1'b1;
                state_next = stat.need_div ? ST_DIV : ST_NEXT;
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.lv_write = 1'b1;
                    state_next   = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (ch_reg)
                    state_next = ST_OUT;
                else
                begin
                    ch_next    = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/htsc_dp.sv
module htsc_dp
    import htsc_pkg::*;
#(
    parameter int QUIET_DEPTH = 32,
    parameter int PEAK_DEPTH  = 8,
    parameter int ENERGY_LEN  = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  cfg_t        cfg,
    output stat_t       stat,
    input  logic [31:0] time_ms,
    input  logic [14:0] sample_a,
    input  logic [14:0] sample_b,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [1:0]  sound,
    output logic [1:0]  heart,
    output logic [1:0]  bowel,
    output logic [22:0] level_a,
    output logic [22:0] level_b,
    output logic [22:0] dev_a,
    output logic [22:0] dev_b
);

    localparam int QP_W   = $clog2(QUIET_DEPTH);
    localparam int QN_W   = $clog2(QUIET_DEPTH + 1);
    localparam int QA_W   = $clog2(2 * QUIET_DEPTH);
    localparam int QSUM_W = SAMPLE_W + QN_W;
    localparam int PP_W   = $clog2(PEAK_DEPTH);
    localparam int PT_W   = $clog2(PEAK_DEPTH + 1);
    localparam int PA_W   = $clog2(2 * PEAK_DEPTH);
    localparam int E_W    = SQ_W + $clog2(ENERGY_LEN);
    localparam int CMP_W  = E_W + 4;
    localparam int EC_W   = $clog2(ENERGY_LEN + 1);
    localparam int DIV_W  = (QSUM_W + 8 > 28) ? QSUM_W + 8 : 28;
    localparam int DVS_W  = (QN_W > 5) ? QN_W : 5;
    localparam logic [31:0] FIFTH_RECIP = 32'hCCCCCCCD;

    // per-channel state
    logic [LEVEL_W-1:0]  level_reg [2];
    logic [LEVEL_W-1:0]  lvout_reg [2];
    logic [LEVEL_W-1:0]  dev_reg [2];
    logic                snd_reg [2];
    logic                above_reg [2];
    logic [QP_W-1:0]     wpos_reg [2];
    logic                full_reg [2];
    logic [QSUM_W-1:0]   qsum_reg [2];
    logic [PP_W-1:0]     ppos_reg [2];
    logic [PT_W-1:0]     ptot_reg [2];
    logic [E_W-1:0]      esum_reg [2];
    logic [TIME_W-1:0]   lforce_reg [2];
    logic                heart_reg [2];
    logic                bowel_reg [2];

    logic [EC_W-1:0]     ecnt_reg;
    logic                win_end_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [SAMPLE_W-1:0] samp_reg [2];

    logic [SAMPLE_W-1:0] qmem [2*QUIET_DEPTH];
    logic [SAMPLE_W-1:0] q_rdata_reg;
    logic [TIME_W-1:0]   pmem [2*PEAK_DEPTH];
    logic [TIME_W-1:0]   p_rdata_reg;

    logic [SQ_W-1:0]     sq_reg;
    logic [PP_W-1:0]     rptr_reg;
    logic [PT_W-1:0]     rk_reg;
    logic [PT_W-1:0]     good_reg;
    logic [TIME_W-1:0]   prev_reg;
    logic [25:0]         drift_x_reg;

    logic                out_valid_reg;
    logic [1:0]          o_snd_reg, o_heart_reg, o_bowel_reg;
    logic [LEVEL_W-1:0]  o_lv_reg [2];
    logic [LEVEL_W-1:0]  o_dev_reg [2];

    // combinational helpers
    logic                c;
    logic [SAMPLE_W-1:0] s;
    logic [LEVEL_W-1:0]  lv, v, dev_c, mul_in;
    logic                above_c;
    logic [QA_W-1:0]     q_addr;
    logic [PA_W-1:0]     p_waddr, p_raddr;
    logic [PT_W:0]       start_t;
    logic [PP_W-1:0]     start_p;
    logic [TIME_W-1:0]   gap;
    logic [EC_W-1:0]     ecnt_inc;
    logic [TIME_W-1:0]   since;
    logic                drift;
    logic [QP_W-1:0]     new_p;
    logic                new_full;
    logic [QSUM_W-1:0]   new_sum;
    logic [QN_W-1:0]     n_q;
    logic [CMP_W-1:0]    lhs, rhs;
    logic                elevated, heart_c;
    logic                div_start, div_busy;
    logic [DIV_W-1:0]    div_dvd, div_quo;
    logic [DVS_W-1:0]    div_dvs;
    logic [27:0]         drift_t;
    logic [57:0]         drift_prod;
    logic [LEVEL_W-1:0]  drift_q;

    always_comb
    begin
        c        = cmd.ch;
        s        = samp_reg[c];
        lv       = level_reg[c];
        v        = {s, 8'b0};
        dev_c    = (v >= lv) ? v - lv : lv - v;
        above_c  = (LEVEL_W'(s) * PEAK_MULT) > lv;
        q_addr   = c ? QA_W'(QUIET_DEPTH) + QA_W'(wpos_reg[c]) : QA_W'(wpos_reg[c]);
        p_waddr  = c ? PA_W'(PEAK_DEPTH) + PA_W'(ppos_reg[c]) : PA_W'(ppos_reg[c]);
        p_raddr  = c ? PA_W'(PEAK_DEPTH) + PA_W'(rptr_reg) : PA_W'(rptr_reg);
        start_t  = (PT_W+1)'(ppos_reg[c]) + (PT_W+1)'(PEAK_DEPTH) - (PT_W+1)'(ptot_reg[c]);
        start_p  = (start_t >= (PT_W+1)'(PEAK_DEPTH))
                   ? PP_W'(start_t - (PT_W+1)'(PEAK_DEPTH)) : PP_W'(start_t);
        gap      = p_rdata_reg - prev_reg;
        ecnt_inc = ecnt_reg + 1'b1;
        since    = time_reg - lforce_reg[c];
        drift    = since > TIME_W'(cfg.force_drift_ms);
        new_p    = (wpos_reg[c] == QP_W'(QUIET_DEPTH - 1)) ? '0 : wpos_reg[c] + 1'b1;
        new_full = full_reg[c] || (new_p == '0);
        new_sum  = qsum_reg[c] + QSUM_W'(s)
                   - (full_reg[c] ? QSUM_W'(q_rdata_reg) : '0);
        n_q      = new_full ? QN_W'(QUIET_DEPTH) : QN_W'(new_p);
        lhs      = (CMP_W'(esum_reg[c]) << 3) + (CMP_W'(esum_reg[c]) << 1);
        rhs      = CMP_W'(sq_reg) * CMP_W'(ENERGY_LEN);
        heart_c  = good_reg >= PT_W'(MIN_GOOD);
        elevated = lhs > rhs;
        mul_in   = cmd.sq_lvl ? lv : dev_reg[c];
        div_dvd  = (DIV_W'(new_sum) << 8) + DIV_W'(n_q >> 1);
        div_dvs  = DVS_W'(n_q);
        div_start = cmd.lv_upd && !snd_reg[c];
        // drift: divide by 20 as a two-bit drop, then times the reciprocal of five
        drift_t    = 28'(lv) * 28'(DRIFT_KEEP) + 28'(v) + 28'(DRIFT_RND);
        drift_prod = 58'(drift_x_reg) * 58'(FIFTH_RECIP);
        drift_q    = drift_prod[34 +: LEVEL_W];

        stat.win_end  = win_end_reg;
        stat.rh_short = ptot_reg[c] < PT_W'(MIN_PEAKS);
        stat.rh_last  = rk_reg == ptot_reg[c] - 1'b1;
        stat.need_div = !snd_reg[c] || drift;
        stat.div_done = !div_busy;
        stat.out_free = !out_valid_reg || out_ready;
    end

    htsc_div #(.DIV_W(DIV_W), .DVS_W(DVS_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // memories and payload
    always_ff @(posedge clk)
    begin
        q_rdata_reg <= qmem[q_addr];
        p_rdata_reg <= pmem[p_raddr];
        if (cmd.lv_upd && !snd_reg[c])
            qmem[q_addr] <= s;
        if (cmd.lv_upd && snd_reg[c])
            drift_x_reg <= drift_t[27:2];
        if (cmd.eval && above_c && !above_reg[c])
            pmem[p_waddr] <= time_reg;
        if (cmd.load_in)
        begin
            time_reg    <= time_ms;
            samp_reg[0] <= sample_a;
            samp_reg[1] <= sample_b;
        end
        if (cmd.eval)
        begin
            lvout_reg[c] <= lv;
            dev_reg[c]   <= dev_c;
            snd_reg[c]   <= dev_c >= cfg.sound_threshold;
        end
        if (cmd.sq_dev || cmd.sq_lvl)
            sq_reg <= mul_in * mul_in;
        if (cmd.rh_init)
        begin
            rptr_reg <= start_p;
            rk_reg   <= '0;
            good_reg <= '0;
        end
        if (cmd.rh_cmp)
        begin
            if (rk_reg != '0 && gap >= TIME_W'(cfg.gap_min_ms)
                && gap <= TIME_W'(cfg.gap_max_ms))
                good_reg <= good_reg + 1'b1;
            prev_reg <= p_rdata_reg;
            rk_reg   <= rk_reg + 1'b1;
            rptr_reg <= (rptr_reg == PP_W'(PEAK_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (cmd.out_load)
        begin
            o_snd_reg   <= {snd_reg[1], snd_reg[0]};
            o_heart_reg <= {heart_reg[1], heart_reg[0]};
            o_bowel_reg <= {bowel_reg[1], bowel_reg[0]};
            o_lv_reg    <= lvout_reg;
            o_dev_reg   <= dev_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                level_reg[i]  <= RESET_LEVEL;
                above_reg[i]  <= 1'b0;
                wpos_reg[i]   <= '0;
                full_reg[i]   <= 1'b0;
                qsum_reg[i]   <= '0;
                ppos_reg[i]   <= '0;
                ptot_reg[i]   <= '0;
                esum_reg[i]   <= '0;
                lforce_reg[i] <= '0;
                heart_reg[i]  <= 1'b0;
                bowel_reg[i]  <= 1'b0;
            end
            ecnt_reg      <= '0;
            win_end_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_in)
            begin
                win_end_reg <= ecnt_inc >= EC_W'(ENERGY_LEN);
                ecnt_reg    <= (ecnt_inc >= EC_W'(ENERGY_LEN)) ? '0 : ecnt_inc;
            end
            if (cmd.eval)
            begin
                above_reg[c] <= above_c;
                if (above_c && !above_reg[c])
                begin
                    ppos_reg[c] <= (ppos_reg[c] == PP_W'(PEAK_DEPTH - 1))
                                   ? '0 : ppos_reg[c] + 1'b1;
                    if (ptot_reg[c] < PT_W'(PEAK_DEPTH))
                        ptot_reg[c] <= ptot_reg[c] + 1'b1;
                end
            end
            if (cmd.acc)
                esum_reg[c] <= esum_reg[c] + E_W'(sq_reg);
            if (cmd.decide)
            begin
                heart_reg[c] <= heart_c;
                bowel_reg[c] <= elevated && !heart_c;
                esum_reg[c]  <= '0;
            end
            if (cmd.lv_upd)
            begin
                if (!snd_reg[c])
                begin
                    wpos_reg[c]   <= new_p;
                    full_reg[c]   <= new_full;
                    qsum_reg[c]   <= new_sum;
                    lforce_reg[c] <= time_reg;
                end
                else if (drift)
                    lforce_reg[c] <= time_reg;
            end
            if (cmd.lv_write)
                level_reg[c] <= snd_reg[c] ? drift_q : div_quo[LEVEL_W-1:0];
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign sound     = o_snd_reg;
    assign heart     = o_heart_reg;
    assign bowel     = o_bowel_reg;
    assign level_a   = o_lv_reg[0];
    assign level_b   = o_lv_reg[1];
    assign dev_a     = o_dev_reg[0];
    assign dev_b     = o_dev_reg[1];

endmodule

// File: rtl/core/heart_tone_sound_classifier.sv
// Two-channel heart tone and bowel sound classifier. Each input word carries
// a millisecond timestamp and one 15-bit ADC code per microphone; each
// produces exactly one result word with per-channel sound, held heart and
// bowel flags, the baseline before the step and the absolute deviation (both
// Q15.8). Words are processed one at a time: a word is accepted, each channel
// is evaluated and its energy accumulated, then its baseline is updated, with
// the bit-serial divider refreshing the mean when a quiet sample comes in
// (one quotient bit per cycle, DIV_W = max(28, 23+clog2(QUIET_DEPTH+1))), or
// with a drift step when a long loud spell drifts the baseline; last the
// result is handed to the output register. An energy-window end adds a rhythm
// check over the logged peaks once enough peaks are logged, and an energy
// decision, per channel. A finished result sits in an output register, so
// the next word is taken while it waits. Configuration goes through the APB
// port at byte addresses 0, 4, 8, 12: sound threshold, shortest gap, longest
// gap, drift time; write only while the block is idle.
module heart_tone_sound_classifier
    import htsc_pkg::*;
#(
    parameter int QUIET_DEPTH = 32,
    parameter int PEAK_DEPTH  = 8,
    parameter int ENERGY_LEN  = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    htsc_in_if.sink     in_ch,
    htsc_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t        cfg_reg;
    cmd_t        cmd;
    stat_t       stat;
    logic [1:0]  reg_idx;
    logic [1:0]  sound, heart, bowel;

    // register index from word address
    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sound_threshold <= 23'd102400;
            cfg_reg.gap_min_ms      <= 16'd333;
            cfg_reg.gap_max_ms      <= 16'd545;
            cfg_reg.force_drift_ms  <= 20'd8000;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                REG_THRESHOLD: cfg_reg.sound_threshold <= pwdata[22:0];
                REG_GAP_MIN:   cfg_reg.gap_min_ms      <= pwdata[15:0];
                REG_GAP_MAX:   cfg_reg.gap_max_ms      <= pwdata[15:0];
                REG_DRIFT:     cfg_reg.force_drift_ms  <= pwdata[19:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_THRESHOLD: prdata = 32'(cfg_reg.sound_threshold);
            REG_GAP_MIN:   prdata = 32'(cfg_reg.gap_min_ms);
            REG_GAP_MAX:   prdata = 32'(cfg_reg.gap_max_ms);
            REG_DRIFT:     prdata = 32'(cfg_reg.force_drift_ms);
            default:       prdata = '0;
        endcase
    end

    // sequencer: walks both channels through evaluate, energy, rhythm, baseline
    htsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: per-channel state, quiet window, peak log, divider, result word
    htsc_dp #(
        .QUIET_DEPTH (QUIET_DEPTH),
        .PEAK_DEPTH  (PEAK_DEPTH),
        .ENERGY_LEN  (ENERGY_LEN)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg_reg),
        .stat      (stat),
        .time_ms   (in_ch.time_ms),
        .sample_a  (in_ch.sample_a),
        .sample_b  (in_ch.sample_b),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .sound     (sound),
        .heart     (heart),
        .bowel     (bowel),
        .level_a   (out_ch.level_a),
        .level_b   (out_ch.level_b),
        .dev_a     (out_ch.dev_a),
        .dev_b     (out_ch.dev_b)
    );

    assign out_ch.sound_a = sound[0];
    assign out_ch.sound_b = sound[1];
    assign out_ch.heart_a = heart[0];
    assign out_ch.heart_b = heart[1];
    assign out_ch.bowel_a = bowel[0];
    assign out_ch.bowel_b = bowel[1];

endmodule
